>>> src/tps_pkg.sv
`timescale 1ns / 1ps

package tps_pkg;

	// Field widths fixed by the item format
	localparam int ID_W       = 8;
	localparam int RSSI_W     = 8;
	localparam int TMO_W      = 8;
	localparam int COUNT_W    = 5;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;

	// At most this many path ids go out per tick
	localparam int MAX_RESULTS = 16;
	localparam int EMIT_W      = 5;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_OWN_ID  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 1'd1;

	// Reset values of the configuration registers
	localparam logic [ID_W-1:0]  OWN_ID_RESET  = 8'd1;
	localparam logic [TMO_W-1:0] TIMEOUT_RESET = 8'd3;

	// Result kinds
	localparam logic KIND_STATUS    = 1'b0;
	localparam logic KIND_BROADCAST = 1'b1;

	// Input actions
	typedef enum logic [1:0] {
		ACT_TICK  = 2'd0,
		ACT_ENTRY = 2'd1,
		ACT_ROOT  = 2'd2
	} action_t;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;
		logic apply_entry;
		logic hello_end;
		logic root;
		logic tick;
		logic rd;
		logic load_status;
		logic load_entry;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic tick_live;
		logic emit_last;
		logic out_free;
	} sts_t;

endpackage

>>> src/tree_parent_selector.sv
`timescale 1ns / 1ps

// Channel   Handshake                    Payload
// item      item_valid / item_stall      action sender_id rssi path_entry entry_valid last_entry
// result    result_valid / result_stall  result_kind has_parent parent_id_out parent_rssi_out
//                                        path_count broadcast_entry run_last updated overflow
// config    cfg_we                       cfg_index cfg_data
//
// The controller walks a path entry that is not last through capture and store steps, the last
// entry of a hello through capture, store, decide and load, a root hello through capture, decide
// and load, and a tick through capture and count-down, then one path store read and one output
// load per emitted id, or one load if no parent is left; an unused action is only captured.
// Reset is asynchronous and active low; the path store needs no clearing pass.
// A stalled result holds the next result load, and with it item_stall, until it is taken.

module tree_parent_selector #(
	parameter int PATH_MAX = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [tps_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tps_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  logic [1:0]                      action,
	input  logic [tps_pkg::ID_W-1:0]        sender_id,
	input  logic [tps_pkg::RSSI_W-1:0]      rssi,
	input  logic [tps_pkg::ID_W-1:0]        path_entry,
	input  logic                            entry_valid,
	input  logic                            last_entry,
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic                            result_kind,
	output logic                            has_parent,
	output logic [tps_pkg::ID_W-1:0]        parent_id_out,
	output logic [tps_pkg::RSSI_W-1:0]      parent_rssi_out,
	output logic [tps_pkg::COUNT_W-1:0]     path_count,
	output logic [tps_pkg::ID_W-1:0]        broadcast_entry,
	output logic                            run_last,
	output logic                            updated,
	output logic                            overflow
);

	import tps_pkg::*;

	cmd_t cmd;
	sts_t sts;

	tps_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.action     (action),
		.last_entry (last_entry),
		.sts        (sts),
		.cmd        (cmd)
	);

	tps_dp #(
		.PATH_MAX (PATH_MAX)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.sender_id       (sender_id),
		.rssi            (rssi),
		.path_entry      (path_entry),
		.entry_valid     (entry_valid),
		.result_stall    (result_stall),
		.result_valid    (result_valid),
		.result_kind     (result_kind),
		.has_parent      (has_parent),
		.parent_id_out   (parent_id_out),
		.parent_rssi_out (parent_rssi_out),
		.path_count      (path_count),
		.broadcast_entry (broadcast_entry),
		.run_last        (run_last),
		.updated         (updated),
		.overflow        (overflow)
	);

endmodule

>>> src/tps_ram.sv
`timescale 1ns / 1ps

module tps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write one word, read one word registered
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> src/tps_ctrl.sv
`timescale 1ns / 1ps

module tps_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_stall,
	input  logic [1:0]    action,
	input  logic          last_entry,
	input  tps_pkg::sts_t sts,
	output tps_pkg::cmd_t cmd
);

	import tps_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE       = 9'b0_0000_0001,
		S_ENTRY_MID  = 9'b0_0000_0010,
		S_ENTRY_LAST = 9'b0_0000_0100,
		S_HELLO_END  = 9'b0_0000_1000,
		S_ROOT       = 9'b0_0001_0000,
		S_TICK       = 9'b0_0010_0000,
		S_READ       = 9'b0_0100_0000,
		S_EMIT       = 9'b0_1000_0000,
		S_DONE       = 9'b1_0000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign item_stall = (state_q != S_IDLE);

	// Sequence one item through the datapath
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.capture = 1'b1;
					if (action == ACT_TICK) begin
						state_d = S_TICK;
					end else if (action == ACT_ENTRY) begin
						state_d = last_entry ? S_ENTRY_LAST : S_ENTRY_MID;
					end else if (action == ACT_ROOT) begin
						state_d = S_ROOT;
					end
				end
			end
			S_ENTRY_MID: begin
				cmd.apply_entry = 1'b1;
				state_d         = S_IDLE;
			end
			S_ENTRY_LAST: begin
				cmd.apply_entry = 1'b1;
				state_d         = S_HELLO_END;
			end
			S_HELLO_END: begin
				cmd.hello_end = 1'b1;
				state_d       = S_DONE;
			end
			S_ROOT: begin
				cmd.root = 1'b1;
				state_d  = S_DONE;
			end
			S_TICK: begin
				cmd.tick = 1'b1;
				state_d  = sts.tick_live ? S_READ : S_DONE;
			end
			S_READ: begin
				cmd.rd  = 1'b1;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.load_entry = 1'b1;
					state_d        = sts.emit_last ? S_IDLE : S_READ;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.load_status = 1'b1;
					state_d         = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef ASSERT_OFF
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.capture, cmd.apply_entry, cmd.hello_end, cmd.root, cmd.tick,
			cmd.rd, cmd.load_status, cmd.load_entry}))
		else $error("more than one datapath command at once");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_status || cmd.load_entry) |-> sts.out_free)
		else $error("output register loaded while occupied");

	a_read_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |=> (state_q == S_EMIT))
		else $error("path read not followed by emit");
`endif

endmodule

>>> src/tps_dp.sv
`timescale 1ns / 1ps

module tps_dp #(
	parameter int PATH_MAX = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  tps_pkg::cmd_t                   cmd,
	output tps_pkg::sts_t                   sts,
	input  logic                            cfg_we,
	input  logic [tps_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tps_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic [tps_pkg::ID_W-1:0]        sender_id,
	input  logic [tps_pkg::RSSI_W-1:0]      rssi,
	input  logic [tps_pkg::ID_W-1:0]        path_entry,
	input  logic                            entry_valid,
	input  logic                            result_stall,
	output logic                            result_valid,
	output logic                            result_kind,
	output logic                            has_parent,
	output logic [tps_pkg::ID_W-1:0]        parent_id_out,
	output logic [tps_pkg::RSSI_W-1:0]      parent_rssi_out,
	output logic [tps_pkg::COUNT_W-1:0]     path_count,
	output logic [tps_pkg::ID_W-1:0]        broadcast_entry,
	output logic                            run_last,
	output logic                            updated,
	output logic                            overflow
);

	import tps_pkg::*;

	localparam int DEPTH   = 2 * PATH_MAX;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int ADDR_W1 = ADDR_W + 1;
	localparam int CNT_W   = $clog2(PATH_MAX + 1);
	localparam int CMP_W   = (CNT_W > EMIT_W) ? CNT_W : EMIT_W;

	// Configuration
	logic [ID_W-1:0]  own_id_q;
	logic [TMO_W-1:0] reload_q;

	// Captured item
	logic [ID_W-1:0]   sender_q;
	logic [RSSI_W-1:0] rssi_q;
	logic [ID_W-1:0]   entry_q;
	logic              entry_valid_q;

	// Parent and run state
	logic              bank_q;
	logic [CNT_W-1:0]  path_len_q;
	logic [CNT_W-1:0]  cand_cnt_q;
	logic              loop_q;
	logic [ID_W-1:0]   par_id_q;
	logic [RSSI_W-1:0] par_str_q;
	logic [TMO_W-1:0]  timeout_q;

	// Pending result flags and emit index
	logic              kind_q;
	logic              upd_q;
	logic              ovf_q;
	logic [EMIT_W-1:0] idx_q;

	// Output register
	logic              out_valid_q;
	logic              out_kind_q;
	logic              out_has_q;
	logic [ID_W-1:0]   out_pid_q;
	logic [RSSI_W-1:0] out_str_q;
	logic [COUNT_W-1:0] out_cnt_q;
	logic [ID_W-1:0]   out_entry_q;
	logic              out_last_q;
	logic              out_upd_q;
	logic              out_ovf_q;

	logic [ADDR_W-1:0] act_base;
	logic [ADDR_W-1:0] cand_base;
	logic [ADDR_W-1:0] wr_addr;
	logic [ID_W-1:0]   wr_data;
	logic              wr_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [ID_W-1:0]   rd_data;

	logic              cnt_room;
	logic              hello_ovf;
	logic              hello_adopt;
	logic              root_refresh;
	logic              root_adopt;
	logic              tick_live;
	logic [EMIT_W-1:0] emit_n;
	logic              emit_last;
	logic              out_free;

	assign act_base  = bank_q ? ADDR_W'(PATH_MAX) : '0;
	assign cand_base = bank_q ? '0 : ADDR_W'(PATH_MAX);

	// Decide on the run and on root hellos
	assign cnt_room    = cand_cnt_q < CNT_W'(PATH_MAX - 1);
	assign hello_ovf   = cand_cnt_q >= CNT_W'(PATH_MAX);
	assign hello_adopt = !hello_ovf && (cand_cnt_q != '0) && !loop_q &&
		((path_len_q == '0) || (sender_q == par_id_q) || (rssi_q > par_str_q));
	assign root_refresh = (path_len_q != '0) && (sender_q == par_id_q);
	assign root_adopt   = !root_refresh && ((path_len_q == '0) || (rssi_q > par_str_q));

	// Parent survives this tick
	assign tick_live = (path_len_q != '0) && (timeout_q != TMO_W'(1));

	// Number of ids to emit and last-entry detect
	assign emit_n = (CMP_W'(path_len_q) >= CMP_W'(MAX_RESULTS)) ?
		EMIT_W'(MAX_RESULTS) : EMIT_W'(path_len_q);
	assign emit_last = (idx_q + EMIT_W'(1)) == emit_n;

	assign out_free = !out_valid_q || !result_stall;

	assign sts.tick_live = tick_live;
	assign sts.emit_last = emit_last;
	assign sts.out_free  = out_free;

	// Path store write port
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cand_base + ADDR_W'(cand_cnt_q);
		wr_data = entry_q;
		if (cmd.apply_entry) begin
			wr_en = entry_valid_q && cnt_room;
		end else if (cmd.hello_end) begin
			wr_en   = hello_adopt;
			wr_data = sender_q;
		end else if (cmd.root) begin
			wr_en   = root_adopt;
			wr_addr = cand_base;
			wr_data = sender_q;
		end
	end

	assign rd_addr = act_base + ADDR_W'(idx_q);

	tps_ram #(
		.WIDTH (ID_W),
		.DEPTH (DEPTH)
	) u_path_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (cmd.rd),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Hold configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q <= OWN_ID_RESET;
			reload_q <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_OWN_ID:  own_id_q <= cfg_data;
				REG_TIMEOUT: reload_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Capture the accepted item
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sender_q      <= sender_id;
			rssi_q        <= rssi;
			entry_q       <= path_entry;
			entry_valid_q <= entry_valid;
		end
	end

	// Update parent, run and emit state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q     <= 1'b0;
			path_len_q <= '0;
			cand_cnt_q <= '0;
			loop_q     <= 1'b0;
			par_id_q   <= '0;
			par_str_q  <= '0;
			timeout_q  <= '0;
			kind_q     <= KIND_STATUS;
			upd_q      <= 1'b0;
			ovf_q      <= 1'b0;
			idx_q      <= '0;
		end else begin
			if (cmd.apply_entry && entry_valid_q) begin
				cand_cnt_q <= cnt_room ? cand_cnt_q + CNT_W'(1) : CNT_W'(PATH_MAX);
				if (entry_q == own_id_q) begin
					loop_q <= 1'b1;
				end
			end
			if (cmd.hello_end) begin
				cand_cnt_q <= '0;
				loop_q     <= 1'b0;
				kind_q     <= KIND_STATUS;
				upd_q      <= hello_adopt;
				ovf_q      <= hello_ovf;
				if (hello_adopt) begin
					bank_q     <= !bank_q;
					path_len_q <= cand_cnt_q + CNT_W'(1);
					par_id_q   <= sender_q;
					par_str_q  <= rssi_q;
					timeout_q  <= reload_q;
				end
			end
			if (cmd.root) begin
				cand_cnt_q <= '0;
				loop_q     <= 1'b0;
				kind_q     <= KIND_STATUS;
				upd_q      <= root_refresh || root_adopt;
				ovf_q      <= 1'b0;
				if (root_refresh) begin
					par_str_q <= rssi_q;
					timeout_q <= reload_q;
				end else if (root_adopt) begin
					bank_q     <= !bank_q;
					path_len_q <= CNT_W'(1);
					par_id_q   <= sender_q;
					par_str_q  <= rssi_q;
					timeout_q  <= reload_q;
				end
			end
			if (cmd.tick) begin
				kind_q <= KIND_BROADCAST;
				upd_q  <= 1'b0;
				ovf_q  <= 1'b0;
				idx_q  <= '0;
				if (path_len_q != '0) begin
					timeout_q <= timeout_q - TMO_W'(1);
					if (!tick_live) begin
						path_len_q <= '0;
						par_str_q  <= '0;
					end
				end
			end
			if (cmd.load_entry) begin
				idx_q <= idx_q + EMIT_W'(1);
			end
		end
	end

	// Output valid: set on load, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_status || cmd.load_entry) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (cmd.load_status || cmd.load_entry) begin
			out_has_q <= (path_len_q != '0);
			out_pid_q <= par_id_q;
			out_str_q <= par_str_q;
			out_cnt_q <= COUNT_W'(path_len_q);
		end
		if (cmd.load_status) begin
			out_kind_q  <= kind_q;
			out_entry_q <= '0;
			out_last_q  <= 1'b1;
			out_upd_q   <= upd_q;
			out_ovf_q   <= ovf_q;
		end else if (cmd.load_entry) begin
			out_kind_q  <= KIND_BROADCAST;
			out_entry_q <= rd_data;
			out_last_q  <= emit_last;
			out_upd_q   <= 1'b0;
			out_ovf_q   <= 1'b0;
		end
	end

	assign result_valid    = out_valid_q;
	assign result_kind     = out_kind_q;
	assign has_parent      = out_has_q;
	assign parent_id_out   = out_pid_q;
	assign parent_rssi_out = out_str_q;
	assign path_count      = out_cnt_q;
	assign broadcast_entry = out_entry_q;
	assign run_last        = out_last_q;
	assign updated         = out_upd_q;
	assign overflow        = out_ovf_q;

`ifndef ASSERT_OFF
	a_wr_cand_bank: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> ({1'b0, wr_addr} >= {1'b0, cand_base}) &&
			({1'b0, wr_addr} < ({1'b0, cand_base} + ADDR_W1'(PATH_MAX))))
		else $error("path write into the active bank");

	a_emit_has_path: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_entry |-> (path_len_q != '0))
		else $error("path entry emitted with no stored path");

	a_tick_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.tick && !tick_live) |=> (path_len_q == '0) && (par_str_q == '0))
		else $error("expired parent not dropped");
`endif

endmodule

>>> tb/tb_tree_parent_selector.sv
`timescale 1ns / 1ps

module tb_tree_parent_selector;
	import tps_pkg::*;

	localparam int PATH_MAX    = 16;
	localparam int SETTLE      = 40;
	localparam int STUCK_LIMIT = 3000;
	localparam int PHASES      = 5;
	localparam int PHASE_ITEMS = 16;
	localparam int SCRIPT_LEN  = 24;
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]        act;
		logic [ID_W-1:0]   sender;
		logic [RSSI_W-1:0] strength;
		logic [ID_W-1:0]   entry;
		logic              filled;
		logic              closing;
	} hello_t;

	typedef struct packed {
		logic               kind;
		logic               held;
		logic [ID_W-1:0]    parent;
		logic [RSSI_W-1:0]  strength;
		logic [COUNT_W-1:0] count;
		logic [ID_W-1:0]    bcast;
		logic               tail;
		logic               refreshed;
		logic               ovf;
	} report_t;

	typedef struct packed {
		hello_t  it;
		logic    typed;
		report_t want;
	} script_row_t;

	localparam report_t NO_CHECK = '0;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  item_valid = 1'b0;
	logic                  item_stall;
	logic [1:0]            action = ACT_TICK;
	logic [ID_W-1:0]       sender_id = '0;
	logic [RSSI_W-1:0]     rssi = '0;
	logic [ID_W-1:0]       path_entry = '0;
	logic                  entry_valid = 1'b0;
	logic                  last_entry = 1'b0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	logic                  result_kind;
	logic                  has_parent;
	logic [ID_W-1:0]       parent_id_out;
	logic [RSSI_W-1:0]     parent_rssi_out;
	logic [COUNT_W-1:0]    path_count;
	logic [ID_W-1:0]       broadcast_entry;
	logic                  run_last;
	logic                  updated;
	logic                  overflow;

	// Tracked copy of the node's parent state
	logic [ID_W-1:0]    path_mem [2*PATH_MAX] = '{default: '0};
	logic               bank_sel = 1'b0;
	logic [COUNT_W-1:0] held_len = '0;
	logic [COUNT_W-1:0] run_len = '0;
	logic               run_loop = 1'b0;
	logic [ID_W-1:0]    parent_q = '0;
	logic [RSSI_W-1:0]  strength_q = '0;
	logic [TMO_W-1:0]   ticks_left = '0;
	logic [ID_W-1:0]    own_q = OWN_ID_RESET;
	logic [TMO_W-1:0]   reload_q = TIMEOUT_RESET;

	report_t parent_reports [$];
	int      fail_count = 0;
	int      items_sent = 0;
	int      stuck_cycles = 0;
	int      send_idle_pct = 0;
	int      recv_idle_pct = 0;

	logic [CFG_DATA_W-1:0] own_plan [PHASES] = '{8'd1, 8'd255, 8'd37, 8'd128, 8'd1};
	logic [CFG_DATA_W-1:0] reload_plan [PHASES] = '{8'd3, 8'd1, 8'd255, 8'd0, 8'd2};

	// Directed items; typed rows carry a result read straight off the state
	script_row_t script [SCRIPT_LEN] = '{
		// tick with no parent right after reset
		'{'{ACT_TICK, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1}, 1'b1,
			'{KIND_BROADCAST, 1'b0, 8'd0, 8'd0, 5'd0, 8'd0, 1'b1, 1'b0, 1'b0}},
		// unused action gives nothing
		'{'{ACT_UNUSED, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1}, 1'b0, NO_CHECK},
		// root hello with no parent
		'{'{ACT_ROOT, 8'd255, 8'd0, 8'd0, 1'b0, 1'b0}, 1'b1,
			'{KIND_STATUS, 1'b1, 8'd255, 8'd0, 5'd1, 8'd0, 1'b1, 1'b1, 1'b0}},
		'{'{ACT_TICK, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0}, 1'b1,
			'{KIND_BROADCAST, 1'b1, 8'd255, 8'd0, 5'd1, 8'd255, 1'b1, 1'b0, 1'b0}},
		// empty hello
		'{'{ACT_ENTRY, 8'd7, 8'd200, 8'd99, 1'b0, 1'b1}, 1'b1,
			'{KIND_STATUS, 1'b1, 8'd255, 8'd0, 5'd1, 8'd0, 1'b1, 1'b0, 1'b0}},
		// hello whose path holds our own id
		'{'{ACT_ENTRY, 8'd0, 8'd0, 8'd9, 1'b1, 1'b0}, 1'b0, NO_CHECK},
		'{'{ACT_ENTRY, 8'd8, 8'd255, 8'd1, 1'b1, 1'b1}, 1'b1,
			'{KIND_STATUS, 1'b1, 8'd255, 8'd0, 5'd1, 8'd0, 1'b1, 1'b0, 1'b0}},
		// stronger neighbour with a three-id path
		'{'{ACT_ENTRY, 8'd0, 8'd0, 8'd10, 1'b1, 1'b0}, 1'b0, NO_CHECK},
		'{'{ACT_ENTRY, 8'hFF, 8'hFF, 8'd0, 1'b1, 1'b0}, 1'b0, NO_CHECK},
		'{'{ACT_ENTRY, 8'd40, 8'd100, 8'hFF, 1'b1, 1'b1}, 1'b0, NO_CHECK},
		// tick in the middle of a run, then the current parent refreshes weaker
		'{'{ACT_ENTRY, 8'd0, 8'd0, 8'd5, 1'b1, 1'b0}, 1'b0, NO_CHECK},
		'{'{ACT_TICK, 8'd1, 8'd2, 8'd3, 1'b0, 1'b1}, 1'b0, NO_CHECK},
		'{'{ACT_ENTRY, 8'd40, 8'd50, 8'd6, 1'b1, 1'b1}, 1'b0, NO_CHECK},
		// root hello drops the run in progress
		'{'{ACT_ENTRY, 8'd0, 8'd0, 8'd77, 1'b1, 1'b0}, 1'b0, NO_CHECK},
		'{'{ACT_ROOT, 8'd40, 8'd0, 8'd0, 1'b0, 1'b0}, 1'b0, NO_CHECK},
		'{'{ACT_ENTRY, 8'd90, 8'd0, 8'd88, 1'b1, 1'b1}, 1'b0, NO_CHECK},
		// switch to a stronger root, then let it time out
		'{'{ACT_ROOT, 8'd200, 8'd10, 8'd0, 1'b0, 1'b0}, 1'b0, NO_CHECK},
		'{'{ACT_TICK, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0}, 1'b0, NO_CHECK},
		'{'{ACT_TICK, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0}, 1'b0, NO_CHECK},
		'{'{ACT_TICK, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0}, 1'b1,
			'{KIND_BROADCAST, 1'b0, 8'd200, 8'd0, 5'd0, 8'd0, 1'b1, 1'b0, 1'b0}},
		'{'{ACT_TICK, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0}, 1'b1,
			'{KIND_BROADCAST, 1'b0, 8'd200, 8'd0, 5'd0, 8'd0, 1'b1, 1'b0, 1'b0}},
		// empty hello with no parent
		'{'{ACT_ENTRY, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0}, 1'b0, NO_CHECK},
		'{'{ACT_ENTRY, 8'd3, 8'd0, 8'd0, 1'b0, 1'b1}, 1'b1,
			'{KIND_STATUS, 1'b0, 8'd200, 8'd0, 5'd0, 8'd0, 1'b1, 1'b0, 1'b0}},
		// root with id zero at full strength
		'{'{ACT_ROOT, 8'd0, 8'd255, 8'd0, 1'b0, 1'b0}, 1'b0, NO_CHECK}
	};

	tree_parent_selector #(
		.PATH_MAX(PATH_MAX)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.action(action),
		.sender_id(sender_id),
		.rssi(rssi),
		.path_entry(path_entry),
		.entry_valid(entry_valid),
		.last_entry(last_entry),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_kind(result_kind),
		.has_parent(has_parent),
		.parent_id_out(parent_id_out),
		.parent_rssi_out(parent_rssi_out),
		.path_count(path_count),
		.broadcast_entry(broadcast_entry),
		.run_last(run_last),
		.updated(updated),
		.overflow(overflow)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic report_t snapshot(logic kind, logic [ID_W-1:0] bcast, logic tail,
		logic refreshed, logic ovf);
		return '{kind, held_len != 0, parent_q, strength_q, held_len, bcast, tail,
			refreshed, ovf};
	endfunction

	function automatic void take_parent(logic [COUNT_W-1:0] len, logic [ID_W-1:0] from,
		logic [RSSI_W-1:0] strength);
		bank_sel = ~bank_sel;
		held_len = len;
		parent_q = from;
		strength_q = strength;
		ticks_left = reload_q;
	endfunction

	// Advance the parent state by one item; queue its results and return how many
	function automatic int track_parent(hello_t it);
		int base;
		int slot;
		int n;
		int i;
		logic refreshed;
		logic ovf;
		base = bank_sel ? PATH_MAX : 0;
		slot = bank_sel ? 0 : PATH_MAX;
		refreshed = 1'b0;
		ovf = 1'b0;
		n = 0;
		case (it.act)
			ACT_TICK: begin
				// count down, drop on expiry, then send out the stored path
				if (held_len != 0) begin
					ticks_left = ticks_left - 1'b1;
					if (ticks_left == 0) begin
						held_len = '0;
						strength_q = '0;
					end
				end
				if (held_len == 0) begin
					parent_reports.push_back(snapshot(KIND_BROADCAST, '0, 1'b1, 1'b0, 1'b0));
					n = 1;
				end else begin
					n = (held_len < MAX_RESULTS) ? held_len : MAX_RESULTS;
					for (i = 0; i < n; i++)
						parent_reports.push_back(snapshot(KIND_BROADCAST,
							path_mem[base + i % PATH_MAX], i + 1 == n, 1'b0, 1'b0));
				end
			end
			ACT_ENTRY: begin
				// buffer the entry in the spare bank, saturate when the store is full
				if (it.filled) begin
					if (run_len < PATH_MAX - 1) begin
						path_mem[slot + run_len] = it.entry;
						run_len = run_len + 1'b1;
					end else begin
						run_len = COUNT_W'(PATH_MAX);
					end
					if (it.entry == own_q)
						run_loop = 1'b1;
				end
				if (it.closing) begin
					if (run_len >= PATH_MAX) begin
						ovf = 1'b1;
					end else if (run_len != 0 && !run_loop && (held_len == 0 ||
						it.sender == parent_q || it.strength > strength_q)) begin
						path_mem[slot + run_len] = it.sender;
						take_parent(run_len + 1'b1, it.sender, it.strength);
						refreshed = 1'b1;
					end
					run_len = '0;
					run_loop = 1'b0;
					parent_reports.push_back(snapshot(KIND_STATUS, '0, 1'b1, refreshed, ovf));
					n = 1;
				end
			end
			ACT_ROOT: begin
				run_len = '0;
				run_loop = 1'b0;
				if (held_len != 0 && it.sender == parent_q) begin
					strength_q = it.strength;
					ticks_left = reload_q;
					refreshed = 1'b1;
				end else if (held_len == 0 || it.strength > strength_q) begin
					path_mem[slot] = it.sender;
					take_parent(COUNT_W'(1), it.sender, it.strength);
					refreshed = 1'b1;
				end
				parent_reports.push_back(snapshot(KIND_STATUS, '0, 1'b1, refreshed, 1'b0));
				n = 1;
			end
			default: n = 0;
		endcase
		return n;
	endfunction

	function automatic string describe(report_t r);
		return $sformatf({"kind %0d held %0d parent %0d rssi %0d count %0d ",
			"entry %0d last %0d upd %0d ovf %0d"},
			r.kind, r.held, r.parent, r.strength, r.count, r.bcast, r.tail, r.refreshed, r.ovf);
	endfunction

	function automatic logic [ID_W-1:0] pick_sender();
		int roll;
		roll = $urandom_range(9);
		if (roll < 4)
			return parent_q;
		if (roll < 7)
			return ID_W'($urandom_range(1, 6));
		return ID_W'($urandom_range(255));
	endfunction

	// Offer one item, hold it until taken, then track it
	task automatic send(input hello_t it, output int n);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		action <= it.act;
		sender_id <= it.sender;
		rssi <= it.strength;
		path_entry <= it.entry;
		entry_valid <= it.filled;
		last_entry <= it.closing;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		n = track_parent(it);
		if (it.act != ACT_UNUSED)
			items_sent++;
	endtask

	// Send a neighbour hello as a run of len entries
	task automatic hello_run(input int len, input int loop_at, input int fill_pct,
		input logic [ID_W-1:0] from, input logic [RSSI_W-1:0] strength);
		hello_t it;
		int i;
		int n;
		for (i = 0; i < len; i++) begin
			it.act = ACT_ENTRY;
			it.closing = (i == len - 1);
			it.filled = ($urandom_range(99) < fill_pct);
			do
				it.entry = ID_W'($urandom_range(255));
			while (it.entry == own_q);
			if (i == loop_at) begin
				it.entry = own_q;
				it.filled = 1'b1;
			end
			it.sender = it.closing ? from : ID_W'($urandom_range(255));
			it.strength = it.closing ? strength : RSSI_W'($urandom_range(255));
			send(it, n);
		end
	endtask

	task automatic random_burst();
		hello_t it;
		int roll;
		int len;
		int loop_at;
		int fill_pct;
		int n;
		roll = $urandom_range(99);
		it.act = ACT_UNUSED;
		it.sender = ID_W'($urandom_range(255));
		it.strength = RSSI_W'($urandom_range(255));
		it.entry = ID_W'($urandom_range(255));
		it.filled = 1'($urandom_range(1));
		it.closing = 1'($urandom_range(1));
		if (roll < 30) begin
			it.act = ACT_TICK;
			send(it, n);
		end else if (roll < 42) begin
			it.act = ACT_ROOT;
			it.sender = pick_sender();
			send(it, n);
		end else if (roll < 45) begin
			send(it, n);
		end else if (roll < 50) begin
			// broken run: entries with no last one, cut off by a root hello
			repeat ($urandom_range(1, 3)) begin
				it.act = ACT_ENTRY;
				it.closing = 1'b0;
				it.entry = ID_W'($urandom_range(255));
				it.filled = 1'($urandom_range(1));
				send(it, n);
			end
			it.act = ACT_ROOT;
			it.sender = pick_sender();
			it.strength = RSSI_W'($urandom_range(255));
			send(it, n);
		end else begin
			len = ($urandom_range(9) == 0) ? $urandom_range(13, 20) : $urandom_range(1, 5);
			loop_at = -1;
			if ($urandom_range(9) == 0)
				loop_at = $urandom_range(len - 1);
			fill_pct = ($urandom_range(19) == 0) ? 0 : 92;
			hello_run(len, loop_at, fill_pct, pick_sender(), RSSI_W'($urandom_range(255)));
		end
	endtask

	// Hold off the sender until every result is back
	task automatic wait_drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (parent_reports.size() != 0)
			@(posedge clk);
	endtask

	task automatic load_settings(input logic [CFG_DATA_W-1:0] own,
		input logic [CFG_DATA_W-1:0] reload);
		cfg_we <= 1'b1;
		cfg_index <= REG_OWN_ID;
		cfg_data <= own;
		@(posedge clk);
		cfg_index <= REG_TIMEOUT;
		cfg_data <= reload;
		@(posedge clk);
		cfg_we <= 1'b0;
		own_q = own;
		reload_q = reload;
	endtask

	// Check results in order, stall at random, watch for a hang
	always @(posedge clk) begin
		report_t got;
		report_t want;
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall))
				stuck_cycles = 0;
			else
				stuck_cycles++;
			if (result_valid && !result_stall) begin
				got = '{result_kind, has_parent, parent_id_out, parent_rssi_out, path_count,
					broadcast_entry, run_last, updated, overflow};
				if (parent_reports.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result: %s", describe(got));
				end else begin
					want = parent_reports.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display("result mismatch: expected %s / got %s",
								describe(want), describe(got));
					end
				end
			end
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("FAIL tree_parent_selector");
				$finish;
			end
		end
		result_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	initial begin
		hello_t it;
		int r;
		int p;
		int n;
		int goal;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 22;
		recv_idle_pct = 86;

		// Walk the directed table
		for (r = 0; r < SCRIPT_LEN; r++) begin
			send(script[r].it, n);
			if (script[r].typed) begin
				repeat (n) void'(parent_reports.pop_back());
				parent_reports.push_back(script[r].want);
			end
		end

		// Fill the store to the brim, walk it on a tick, then overflow it twice
		hello_run(PATH_MAX - 1, -1, 100, parent_q, 8'd0);
		it = '{ACT_TICK, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0};
		send(it, n);
		hello_run(PATH_MAX, -1, 100, parent_q, 8'hFF);
		hello_run(PATH_MAX + 4, -1, 100, 8'd99, 8'hFF);

		// Random items over several register settings
		for (p = 0; p < PHASES; p++) begin
			if (p != 0) begin
				wait_drain();
				repeat (SETTLE) @(posedge clk);
				load_settings(own_plan[p], reload_plan[p]);
			end
			send_idle_pct = (p < 2) ? 22 : (p < 4) ? 86 : 0;
			recv_idle_pct = (p < 2) ? 86 : (p < 4) ? 22 : 0;
			goal = items_sent + PHASE_ITEMS;
			while (items_sent < goal) begin
				if ($urandom_range(24) == 0)
					wait_drain();
				random_burst();
			end
		end

		wait_drain();
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0)
			$display("PASS tree_parent_selector");
		else
			$display("FAIL tree_parent_selector");
		$finish;
	end

endmodule

>>> tree_parent_selector.f
src/tps_pkg.sv
src/tps_ram.sv
src/tps_ctrl.sv
src/tps_dp.sv
src/tree_parent_selector.sv
tb/tb_tree_parent_selector.sv
